// ===== src/utf8sd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Lead byte classes.
    localparam logic [7:0] CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] CONT_CODE  = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
    localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_CODE = 8'b1111_0000;

    // Smallest legal value for each sequence length.
    localparam logic [CP_W-1:0] MIN_CP2 = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP3 = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP4 = 21'h10000;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last_result;
    } result_t;

    // Results produced by one decode step, oldest in res0.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_push_t;

endpackage

// ===== src/utf8sd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_decode
// Sequence state and the single-pass decode of one registered byte.
// ----------------------------------------------------------------------------
module utf8sd_decode
    import utf8sd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  item_t     item,
    output dec_push_t push
);

    logic [1:0]      remain_reg, remain_next;
    logic [CP_W-1:0] acc_reg, acc_next;
    logic [2:0]      len_reg, len_next;
    logic            start_reg, start_next;

    always_comb
    begin
        logic            is_cont;
        logic            do_start;
        logic            hit;
        logic [1:0]      n;
        logic [7:0]      b;
        logic [CP_W-1:0] min_cp;
        result_t         r0;
        result_t         r1;
        result_t         sres;

        b           = item.data_byte;
        is_cont     = (b & CONT_MASK) == CONT_CODE;
        remain_next = remain_reg;
        acc_next    = acc_reg;
        len_next    = len_reg;
        n           = 2'd0;
        r0          = '0;
        r1          = '0;
        sres        = '0;
        hit         = 1'b0;
        do_start    = 1'b0;
        min_cp      = MIN_CP4;

        if (remain_reg != 2'd0)
        begin
            if (is_cont)
            begin
                acc_next    = {acc_reg[CP_W-7:0], b[5:0]};
                remain_next = remain_reg - 2'd1;
                if (remain_next == 2'd0)
                begin
                    if (len_reg == SEQ_LEN2)
                        min_cp = MIN_CP2;
                    else if (len_reg == SEQ_LEN3)
                        min_cp = MIN_CP3;
                    // The two-byte null is accepted in this modified form.
                    if (acc_next < min_cp && !(len_reg == SEQ_LEN2 && acc_next == '0))
                        r0.is_error = 1'b1;
                    else
                        r0.code_point = acc_next;
                    n           = 2'd1;
                    remain_next = 2'd0;
                    acc_next    = '0;
                    len_next    = '0;
                end
                else if (item.end_of_buffer)
                begin
                    r0.is_error = 1'b1;
                    n           = 2'd1;
                end
            end
            else
            begin
                // Broken sequence: flag it, then decode this byte afresh.
                r0.is_error = 1'b1;
                n           = 2'd1;
                remain_next = 2'd0;
                acc_next    = '0;
                len_next    = '0;
                do_start    = 1'b1;
            end
        end
        else
        begin
            do_start = 1'b1;
        end

        if (do_start)
        begin
            priority if (b[7] == 1'b0)
            begin
                sres.code_point = {{(CP_W-8){1'b0}}, b};
                hit             = 1'b1;
            end
            else if (is_cont)
            begin
                sres.is_error = 1'b1;
                hit           = start_reg;
            end
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                len_next    = SEQ_LEN2;
                acc_next    = {{(CP_W-5){1'b0}}, b[4:0]};
                remain_next = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                len_next    = SEQ_LEN3;
                acc_next    = {{(CP_W-4){1'b0}}, b[3:0]};
                remain_next = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_CODE)
            begin
                len_next    = SEQ_LEN4;
                acc_next    = {{(CP_W-3){1'b0}}, b[2:0]};
                remain_next = 2'd3;
            end
            else
            begin
                sres.is_error = 1'b1;
                hit           = 1'b1;
            end

            // A lead byte on the last byte of a buffer is a truncation.
            if (remain_next != 2'd0 && item.end_of_buffer)
            begin
                sres.is_error = 1'b1;
                hit           = 1'b1;
            end

            if (hit)
            begin
                if (n == 2'd0)
                    r0 = sres;
                else
                    r1 = sres;
                n = n + 2'd1;
            end
        end

        if (n == 2'd1)
            r0.last_result = 1'b1;
        else if (n == 2'd2)
            r1.last_result = 1'b1;

        if (item.end_of_buffer)
        begin
            remain_next = 2'd0;
            acc_next    = '0;
            len_next    = '0;
        end
        start_next = item.end_of_buffer;

        push.count = step ? n : 2'd0;
        push.res0  = r0;
        push.res1  = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 2'd0;
            acc_reg    <= '0;
            len_reg    <= '0;
            start_reg  <= 1'b1;
        end
        else if (step)
        begin
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
            len_reg    <= len_next;
            start_reg  <= start_next;
        end
    end

endmodule

// ===== src/utf8sd_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8sd_out_queue
// Small result queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module utf8sd_out_queue
    import utf8sd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_push_t push,
    output logic      room,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result
);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;
    logic [QPTR_W-1:0] wr_plus1;

    assign result_valid = cnt_reg != '0;
    assign result       = entry_reg[rd_reg];
    assign pop          = result_valid && result_ready;
    // Room for a full two-result step, independent of this cycle's pop.
    assign room         = cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign wr_plus1     = wr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_next  = wr_reg + QPTR_W'(push.count);
        rd_next  = pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_reg] <= push.res0;
        if (push.count == 2'd2)
            entry_reg[wr_plus1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/utf8_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a UTF-8 byte stream (modified form, C0 80 accepted as null) into
// code points and error marks.
// ----------------------------------------------------------------------------
// Usage: bytes arrive as beats on the item channel (item_valid/item_ready),
// each with an end_of_buffer flag. Decoded results leave as beats on the
// result channel (result_valid/result_ready). A byte gives zero, one or two
// result beats; last_result marks the final beat that a byte caused.
// Path: a byte is captured in the input register on acceptance, decoded
// from that register once the queue has room for its results and written
// to a four-entry result queue, from which its result beats are offered.
// Throughput: one byte per cycle while the queue has room for two more
// results. The result queue drains one beat per cycle while result_ready is
// high, so bytes that give two results build up entries; the queue absorbs
// those and input keeps flowing while it has room for two more results.
// Stall: when the receiver holds result_ready low, the queue fills and
// item_ready drops once the input register holds a byte that cannot be
// placed. Nothing is lost or repeated.
// Reset: rst_n clears all sequence state and the queue; the first byte
// after reset counts as the start of a buffer.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
    import utf8sd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic      hold_valid_reg, hold_valid_next;
    item_t     hold_reg;
    logic      room;
    logic      step;
    dec_push_t push;

    // The held byte is decoded whenever the queue can take both results.
    assign step            = hold_valid_reg && room;
    assign item_ready      = !hold_valid_reg || step;
    assign hold_valid_next = item_ready ? item_valid : hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            hold_reg <= item;
    end

    utf8sd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (hold_reg),
        .push  (push)
    );

    utf8sd_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
